// ===== rtl/rsi_pkg.sv =====
// ============================================================================
// rsi_pkg: shared types and constants for the ray / sphere intersection block
// Holds the fixed-point widths of every pipeline quantity and the item types.
// ============================================================================
`default_nettype none

package rsi_pkg;

  // Fraction bits of the fixed-point format.
  localparam int FracBits = 16;

  // Port field widths.
  localparam int CoordW = 32;
  localparam int DirW   = 18;
  localparam int RadW   = 31;
  localparam int DistW  = 31;

  // Internal widths, all exact.
  localparam int OcW    = CoordW + 1;
  localparam int BpW    = OcW + DirW;
  localparam int BW     = BpW + 2;
  localparam int CW     = 2 * OcW + 2;
  localparam int LoW    = (BW + 1) / 2;
  localparam int HiW    = BW - LoW;
  localparam int B2W    = 2 * BW;
  localparam int DiscW  = ((B2W > CW + 2 * FracBits) ? B2W : (CW + 2 * FracBits)) + 1;
  localparam int RootW  = DiscW / 2;
  localparam int SqInW  = 2 * RootW;
  localparam int RemW   = RootW + 3;
  localparam int TW     = BW + 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DirW-1:0]   dir_t;
  typedef logic        [RadW-1:0]   rad_t;
  typedef logic        [DistW-1:0]  dist_t;
  typedef logic signed [OcW-1:0]    oc_t;
  typedef logic        [OcW-1:0]    ocmag_t;
  typedef logic signed [BpW-1:0]    bp_t;
  typedef logic        [2*OcW-1:0]  sq_t;
  typedef logic        [2*RadW-1:0] rr_t;
  typedef logic signed [BW-1:0]     b_t;
  typedef logic        [BW-1:0]     bmag_t;
  typedef logic signed [CW-1:0]     c_t;
  typedef logic        [2*LoW-1:0]  pp_t;
  typedef logic        [B2W-1:0]    b2_t;
  typedef logic signed [DiscW-1:0]  disc_t;
  typedef logic        [SqInW-1:0]  sqin_t;
  typedef logic        [RootW-1:0]  root_t;
  typedef logic        [RemW-1:0]   rem_t;
  typedef logic signed [TW-1:0]     t_t;

  // One input word, unpacked.
  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    dir_t   dir_x;
    dir_t   dir_y;
    dir_t   dir_z;
    coord_t center_x;
    coord_t center_y;
    coord_t center_z;
    rad_t   sphere_radius;
  } ray_t;

  // Side data that travels beside the square root.
  typedef struct packed {
    b_t   b;
    logic miss;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/rsi_front.sv =====
// ============================================================================
// rsi_front: offset, products and dot-product sums
// Three stages: oc = origin - center, the per-axis products, then b and c.
// ============================================================================
`default_nettype none

module rsi_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire rsi_pkg::ray_t ray_i,
  output logic               valid_o,
  output rsi_pkg::b_t        b_o,
  output rsi_pkg::c_t        c_o
);

  logic            v1_q, v2_q, v3_q;
  rsi_pkg::oc_t    oc_q [3];
  rsi_pkg::oc_t    oc_d [3];
  rsi_pkg::dir_t   dir_q [3];
  rsi_pkg::rad_t   r_q;
  rsi_pkg::bp_t    bp_q [3];
  rsi_pkg::bp_t    bp_d [3];
  rsi_pkg::sq_t    sq_q [3];
  rsi_pkg::sq_t    sq_d [3];
  rsi_pkg::rr_t    rr_q;
  rsi_pkg::b_t     b_q, b_d;
  rsi_pkg::c_t     c_q, c_d;

  // Stage 1: offset from the sphere center.
  always_comb begin
    oc_d[0] = rsi_pkg::oc_t'(ray_i.origin_x) - rsi_pkg::oc_t'(ray_i.center_x);
    oc_d[1] = rsi_pkg::oc_t'(ray_i.origin_y) - rsi_pkg::oc_t'(ray_i.center_y);
    oc_d[2] = rsi_pkg::oc_t'(ray_i.origin_z) - rsi_pkg::oc_t'(ray_i.center_z);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oc_q     <= oc_d;
      dir_q[0] <= ray_i.dir_x;
      dir_q[1] <= ray_i.dir_y;
      dir_q[2] <= ray_i.dir_z;
      r_q      <= ray_i.sphere_radius;
    end
  end

  // Stage 2: one multiplier per term.
  always_comb begin
    rsi_pkg::ocmag_t m;
    for (int i = 0; i < 3; i++) begin
      m        = rsi_pkg::ocmag_t'(oc_q[i][rsi_pkg::OcW-1] ? -oc_q[i] : oc_q[i]);
      bp_d[i]  = rsi_pkg::bp_t'(oc_q[i]) * rsi_pkg::bp_t'(dir_q[i]);
      sq_d[i]  = rsi_pkg::sq_t'(m) * rsi_pkg::sq_t'(m);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bp_q <= bp_d;
      sq_q <= sq_d;
      rr_q <= rsi_pkg::rr_t'(r_q) * rsi_pkg::rr_t'(r_q);
    end
  end

  // Stage 3: sums for b and c.
  always_comb begin
    b_d = rsi_pkg::b_t'(bp_q[0]) + rsi_pkg::b_t'(bp_q[1]) + rsi_pkg::b_t'(bp_q[2]);
    c_d = rsi_pkg::c_t'(sq_q[0]) + rsi_pkg::c_t'(sq_q[1]) + rsi_pkg::c_t'(sq_q[2])
        - rsi_pkg::c_t'(rr_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_q <= b_d;
      c_q <= c_d;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign valid_o = v3_q;
  assign b_o     = b_q;
  assign c_o     = c_q;

endmodule

`default_nettype wire

// ===== rtl/rsi_disc.sv =====
// ============================================================================
// rsi_disc: discriminant
// Two stages: partial products of |b| squared, then disc = b^2 - (c << 2F).
// ============================================================================
`default_nettype none

module rsi_disc (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  input  wire logic         valid_i,
  input  wire rsi_pkg::b_t  b_i,
  input  wire rsi_pkg::c_t  c_i,
  output logic              valid_o,
  output rsi_pkg::side_t    side_o,
  output rsi_pkg::sqin_t    x_o
);

  logic           v1_q, v2_q;
  rsi_pkg::bmag_t bm;
  rsi_pkg::pp_t   hh_q, hl_q, ll_q;
  rsi_pkg::b_t    b1_q;
  rsi_pkg::c_t    c1_q;
  rsi_pkg::b2_t   b2;
  rsi_pkg::disc_t disc;
  rsi_pkg::side_t side_q, side_d;
  rsi_pkg::sqin_t x_q, x_d;

  // Stage 1: split |b| into halves and multiply them.
  assign bm = rsi_pkg::bmag_t'(b_i[rsi_pkg::BW-1] ? -b_i : b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= rsi_pkg::pp_t'(bm[rsi_pkg::BW-1:rsi_pkg::LoW])
            * rsi_pkg::pp_t'(bm[rsi_pkg::BW-1:rsi_pkg::LoW]);
      hl_q <= rsi_pkg::pp_t'(bm[rsi_pkg::BW-1:rsi_pkg::LoW])
            * rsi_pkg::pp_t'(bm[rsi_pkg::LoW-1:0]);
      ll_q <= rsi_pkg::pp_t'(bm[rsi_pkg::LoW-1:0]) * rsi_pkg::pp_t'(bm[rsi_pkg::LoW-1:0]);
      b1_q <= b_i;
      c1_q <= c_i;
    end
  end

  // Stage 2: recombine b^2 and subtract the scaled c.
  always_comb begin
    b2 = (rsi_pkg::b2_t'(hh_q) << (2 * rsi_pkg::LoW))
       + (rsi_pkg::b2_t'(hl_q) << (rsi_pkg::LoW + 1))
       + rsi_pkg::b2_t'(ll_q);
    disc = rsi_pkg::disc_t'(b2) - (rsi_pkg::disc_t'(c1_q) <<< (2 * rsi_pkg::FracBits));
    side_d.b    = b1_q;
    side_d.miss = disc[rsi_pkg::DiscW-1];
    x_d = side_d.miss ? '0 : rsi_pkg::sqin_t'(disc);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      x_q    <= x_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign side_o  = side_q;
  assign x_o     = x_q;

endmodule

`default_nettype wire

// ===== rtl/rsi_sqrt.sv =====
// ============================================================================
// rsi_sqrt: pipelined integer square root
// Restoring digit-by-digit root, one result bit per stage.
// ============================================================================
`default_nettype none

module rsi_sqrt (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire rsi_pkg::side_t  side_i,
  input  wire rsi_pkg::sqin_t  x_i,
  output logic                 valid_o,
  output rsi_pkg::side_t       side_o,
  output rsi_pkg::root_t       root_o
);

  localparam int N = rsi_pkg::RootW;

  logic           v_q    [N];
  rsi_pkg::rem_t  rem_q  [N];
  rsi_pkg::root_t root_q [N];
  rsi_pkg::sqin_t x_q    [N];
  rsi_pkg::side_t side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           v_in;
    rsi_pkg::rem_t  rem_in, cur, trial, rem_d;
    rsi_pkg::root_t root_in, root_d;
    rsi_pkg::sqin_t x_in;
    rsi_pkg::side_t side_in;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = x_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign x_in    = x_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Bring down the next two bits and try the next root bit.
    always_comb begin
      cur   = {rem_in[rsi_pkg::RemW-3:0], x_in[rsi_pkg::SqInW-1-2*k -: 2]};
      trial = rsi_pkg::rem_t'({root_in, 2'b01});
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {root_in[N-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {root_in[N-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        x_q[k]    <= x_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign side_o  = side_q[N-1];
  assign root_o  = root_q[N-1];

  typedef logic [rsi_pkg::SqInW:0] chk_t;

  // The root is the floor of the square root of the radicand.
  a_root_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[N-1] |-> (chk_t'(root_q[N-1]) * chk_t'(root_q[N-1])) <= chk_t'(x_q[N-1]))
    else $error("square root too large");

  a_root_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[N-1] |->
      ((chk_t'(root_q[N-1]) + 1'b1) * (chk_t'(root_q[N-1]) + 1'b1)) > chk_t'(x_q[N-1]))
    else $error("square root too small");

  // A miss feeds a zero radicand, so its root is zero.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[N-1] && side_q[N-1].miss) |-> (root_q[N-1] == '0))
    else $error("miss carried a nonzero root");

endmodule

`default_nettype wire

// ===== rtl/ray_sphere_intersect_top.sv =====
// ============================================================================
// ray_sphere_intersect_top: fixed-point ray / sphere hit test
// Streams one test per word and returns hit flag and distance to first hit.
// ============================================================================
// The block takes one word per clock cycle unless the output holds it, and
// returns one result word per input word, in order. Three stages form the
// offset, products and dot sums, two stages form the discriminant, 53 stages
// of the square-root chain yield one root bit each, and one stage picks the
// root and saturates the distance. All stages share one advance enable driven
// by the output register, so a held result stops the whole pipeline without loss.
`default_nettype none

module ray_sphere_intersect_top (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, center_x, center_y,
  // center_z, sphere_radius, zero pad
  input  wire logic [279:0]  s_axis_tdata_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // hit_distance, zero pad
  output logic [31:0]        m_axis_tdata_o,
  // hit
  output logic               m_axis_tuser_o
);

  logic            en;
  rsi_pkg::ray_t   ray;
  logic            f_valid;
  rsi_pkg::b_t     f_b;
  rsi_pkg::c_t     f_c;
  logic            d_valid;
  rsi_pkg::side_t  d_side;
  rsi_pkg::sqin_t  d_x;
  logic            s_valid;
  rsi_pkg::side_t  s_side;
  rsi_pkg::root_t  s_root;
  rsi_pkg::t_t     t0, t1, t;
  logic            hit_d, hit_q, out_v_q;
  rsi_pkg::dist_t  dist_d, dist_q;

  // The pipeline moves whenever the output register can take a word.
  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Unpack the input word.
  always_comb begin
    ray.origin_x      = s_axis_tdata_i[31:0];
    ray.origin_y      = s_axis_tdata_i[63:32];
    ray.origin_z      = s_axis_tdata_i[95:64];
    ray.dir_x         = s_axis_tdata_i[113:96];
    ray.dir_y         = s_axis_tdata_i[131:114];
    ray.dir_z         = s_axis_tdata_i[149:132];
    ray.center_x      = s_axis_tdata_i[181:150];
    ray.center_y      = s_axis_tdata_i[213:182];
    ray.center_z      = s_axis_tdata_i[245:214];
    ray.sphere_radius = s_axis_tdata_i[276:246];
  end

  rsi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid_i),
    .ray_i   (ray),
    .valid_o (f_valid),
    .b_o     (f_b),
    .c_o     (f_c)
  );

  rsi_disc u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .b_i     (f_b),
    .c_i     (f_c),
    .valid_o (d_valid),
    .side_o  (d_side),
    .x_o     (d_x)
  );

  rsi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_valid),
    .side_i  (d_side),
    .x_i     (d_x),
    .valid_o (s_valid),
    .side_o  (s_side),
    .root_o  (s_root)
  );

  // Pick the near root if positive, else the far one, and saturate.
  always_comb begin
    t0 = -rsi_pkg::t_t'(s_side.b) - rsi_pkg::t_t'(s_root);
    t1 = -rsi_pkg::t_t'(s_side.b) + rsi_pkg::t_t'(s_root);
    t  = (t0 > 0) ? t0 : t1;
    hit_d = !s_side.miss && ((t0 > 0) || (t1 > 0));
    if (!hit_d) begin
      dist_d = '0;
    end else if (|t[rsi_pkg::TW-1:rsi_pkg::FracBits+rsi_pkg::DistW]) begin
      dist_d = '1;
    end else begin
      dist_d = t[rsi_pkg::FracBits+rsi_pkg::DistW-1:rsi_pkg::FracBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= s_valid;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = hit_q;
  assign m_axis_tdata_o  = {1'b0, dist_q};

  // A miss always reports zero distance.
  a_miss_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !hit_q) |-> (dist_q == '0))
    else $error("miss with nonzero distance");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ============================================================================
// testbench: self-checking bench for the ray / sphere intersection block
// Drives a table of directed tests, then random rays against random spheres,
// with random gaps on both stream sides, and checks every result word against
// an exact wide-integer prediction of the hit flag and distance.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int RandItems = 1700;
  localparam int IdleLimit = 20000;
  localparam int TailWait  = 200;

  typedef struct packed {
    logic           hit;
    rsi_pkg::dist_t distance;
  } hit_t;

  typedef struct {
    rsi_pkg::ray_t ray;
    logic          known;
    hit_t          want;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_hit;
  logic [279:0] in_data;
  logic [31:0]  out_data;

  hit_t hit_queue[$];
  hit_t fixed_queue[$];
  logic known_queue[$];
  row_t rows[$];
  int   fail_count = 0;
  int   idle_cycles;

  ray_sphere_intersect_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready),
    .s_axis_tdata_i(in_data),
    .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready),
    .m_axis_tdata_o(out_data), .m_axis_tuser_o(out_hit)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Exact prediction: all products at 256 bits, signed.
  function automatic hit_t predict_hit(rsi_pkg::ray_t r);
    logic signed [255:0] ocx, ocy, ocz, dx, dy, dz, bdot, cdot, disc, s, t0, t1, q;
    logic [255:0] sq, cand;
    hit_t res;
    ocx = 256'(signed'(r.origin_x)) - 256'(signed'(r.center_x));
    ocy = 256'(signed'(r.origin_y)) - 256'(signed'(r.center_y));
    ocz = 256'(signed'(r.origin_z)) - 256'(signed'(r.center_z));
    dx = 256'(signed'(r.dir_x));
    dy = 256'(signed'(r.dir_y));
    dz = 256'(signed'(r.dir_z));
    bdot = ocx * dx + ocy * dy + ocz * dz;
    cdot = ocx * ocx + ocy * ocy + ocz * ocz - 256'(r.sphere_radius) * 256'(r.sphere_radius);
    disc = bdot * bdot - (cdot <<< (2 * rsi_pkg::FracBits));
    res = '0;
    if (disc < 0) return res;
    // Bitwise integer square root, 64 result bits.
    sq = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = sq | (256'(1) << i);
      if (cand * cand <= 256'(disc)) sq = cand;
    end
    s = signed'(sq);
    t0 = -bdot - s;
    t1 = -bdot + s;
    if (t0 > 0) q = t0;
    else if (t1 > 0) q = t1;
    else return res;
    q = q >>> rsi_pkg::FracBits;
    res.hit = 1'b1;
    res.distance = (q > 256'sh7FFFFFFF) ? rsi_pkg::dist_t'('1) : rsi_pkg::dist_t'(q);
    return res;
  endfunction

  task automatic report_mismatch(string what, hit_t got, hit_t want);
    $display("mismatch %s: got hit=%0b dist=%h, want hit=%0b dist=%h",
             what, got.hit, got.distance, want.hit, want.distance);
    fail_count++;
  endtask

  // Send one ray; its prediction is queued at acceptance.
  task automatic send_ray(rsi_pkg::ray_t r, logic known, hit_t want);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {3'b000, r.sphere_radius, r.center_z, r.center_y, r.center_x,
                 r.dir_z, r.dir_y, r.dir_x, r.origin_z, r.origin_y, r.origin_x};
    do @(posedge clk); while (!in_ready);
    hit_queue.insert(hit_queue.size(), predict_hit(r));
    known_queue.insert(known_queue.size(), known);
    fixed_queue.insert(fixed_queue.size(), want);
  endtask

  function automatic rsi_pkg::ray_t random_ray();
    rsi_pkg::ray_t r;
    logic [287:0] raw;
    int sc;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
    r = rsi_pkg::ray_t'(raw[$bits(rsi_pkg::ray_t)-1:0]);
    case ($urandom_range(0, 3))
      0: ;  // full-range noise
      default: begin
        // Shaped scene: coordinates within 2^sc in magnitude so hits are common.
        sc = $urandom_range(4, 24);
        r.origin_x = rsi_pkg::coord_t'($signed($urandom) >>> (31 - sc));
        r.origin_y = rsi_pkg::coord_t'($signed($urandom) >>> (31 - sc));
        r.origin_z = rsi_pkg::coord_t'($signed($urandom) >>> (31 - sc));
        r.center_x = rsi_pkg::coord_t'($signed($urandom) >>> (31 - sc));
        r.center_y = rsi_pkg::coord_t'($signed($urandom) >>> (31 - sc));
        r.center_z = rsi_pkg::coord_t'($signed($urandom) >>> (31 - sc));
        r.sphere_radius = rsi_pkg::rad_t'($urandom >> (31 - sc));
        r.dir_x = rsi_pkg::dir_t'($urandom_range(0, 131072)) - rsi_pkg::dir_t'(65536);
        r.dir_y = rsi_pkg::dir_t'($urandom_range(0, 131072)) - rsi_pkg::dir_t'(65536);
        r.dir_z = rsi_pkg::dir_t'($urandom_range(0, 131072)) - rsi_pkg::dir_t'(65536);
      end
    endcase
    return r;
  endfunction

  function automatic rsi_pkg::ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                             int cx, int cy, int cz, int rad);
    rsi_pkg::ray_t r;
    r.origin_x = rsi_pkg::coord_t'(ox);
    r.origin_y = rsi_pkg::coord_t'(oy);
    r.origin_z = rsi_pkg::coord_t'(oz);
    r.dir_x = rsi_pkg::dir_t'(dx);
    r.dir_y = rsi_pkg::dir_t'(dy);
    r.dir_z = rsi_pkg::dir_t'(dz);
    r.center_x = rsi_pkg::coord_t'(cx);
    r.center_y = rsi_pkg::coord_t'(cy);
    r.center_z = rsi_pkg::coord_t'(cz);
    r.sphere_radius = rsi_pkg::rad_t'(rad);
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(rsi_pkg::ray_t r, logic known, hit_t want);
    row_t row;
    row.ray   = r;
    row.known = known;
    row.want  = want;
    rows.insert(rows.size(), row);
  endfunction

  // Result side: random stalls and the field-by-field check.
  always @(posedge clk) begin
    hit_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.hit = out_hit;
        got.distance = out_data[rsi_pkg::DistW-1:0];
        if (hit_queue.size() == 0) begin
          report_mismatch("unexpected word", got, '0);
        end else begin
          want = hit_queue.pop_front();
          if (known_queue.pop_front() && fixed_queue[0] !== want)
            report_mismatch("table entry", want, fixed_queue[0]);
          void'(fixed_queue.pop_front());
          if (got.hit !== want.hit) report_mismatch("hit flag", got, want);
          if (got.distance !== want.distance) report_mismatch("distance", got, want);
          if (out_data[31] !== 1'b0) report_mismatch("pad bit", got, want);
        end
      end
      if ($urandom_range(0, 15) == 0) out_ready <= 1'b0;
      else if ($urandom_range(0, 3) == 0) out_ready <= 1'b1;
      else if (!out_ready && $urandom_range(0, 30) == 0) out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (!rst_n) idle_cycles <= 0;
    else if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    hit_t none;
    int k;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;

    // Directed rows: ray along +x toward a unit sphere (hit at 4), ray away
    // (miss), origin inside (far root), tangent, zero radius, all extremes.
    add_row(make_ray(-5 << 16, 0, 0, 65536, 0, 0, 0, 0, 0, 1 << 16), 1'b1,
            '{1'b1, 31'(4 << 16)});
    add_row(make_ray(-5 << 16, 0, 0, -65536, 0, 0, 0, 0, 0, 1 << 16), 1'b1, none);
    add_row(make_ray(0, 0, 0, 0, 65536, 0, 0, 0, 0, 2 << 16), 1'b1,
            '{1'b1, 31'(2 << 16)});
    add_row(make_ray(0, 0, 0, 0, 0, -65536, 0, 0, 0, 2 << 16), 1'b1,
            '{1'b1, 31'(2 << 16)});
    add_row(make_ray(0, 1 << 16, -3 << 16, 0, 0, 65536, 0, 0, 0, 1 << 16), 1'b0, none);
    add_row(make_ray(0, 5 << 16, 0, 65536, 0, 0, 0, 0, 0, 1 << 16), 1'b1, none);
    add_row(make_ray(0, 0, 0, 65536, 0, 0, 0, 0, 0, 0), 1'b1, none);
    add_row(make_ray(1, 0, 0, 65536, 0, 0, 0, 0, 0, 1), 1'b0, none);
    add_row(make_ray(0, 0, 0, 65536, 0, 0, 3, 0, 0, 2), 1'b0, none);
    add_row(make_ray(32'h80000000, 0, 0, 65536, 0, 0, 32'h7FFFFFFF, 0, 0, 1 << 16),
            1'b0, none);
    add_row(make_ray(32'h80000000, 32'h80000000, 32'h80000000, -65536, -65536,
            -65536, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, none);
    add_row(make_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 65536, 65536, 65536,
            32'h80000000, 32'h80000000, 32'h80000000, 0), 1'b0, none);
    add_row(make_ray(0, 0, 0, 131071, -131072, 131071, 32'h7FFFFFFF, 0, 0,
            32'h7FFFFFFF), 1'b0, none);
    add_row(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, 32'h7FFFFFFF), 1'b0, none);
    add_row(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 1 << 16), 1'b0, none);
    add_row(make_ray(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'h15555, 32'h2AAAA,
            32'h15555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h2AAAAAAA), 1'b0, none);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_ray(rows[i].ray, rows[i].known, rows[i].want);
    for (k = 0; k < RandItems; k++) send_ray(random_ray(), 1'b0, none);
    in_valid <= 1'b0;

    while (hit_queue.size() != 0) @(posedge clk);
    repeat (TailWait) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
